### hw/rtl/biquad_iir_cascade_macros.svh
// ----------------------------------------------------------------------------
// Biquad cascade assertion macros
// Shared assertion forms for the biquad cascade. Each one expects signals
// named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_CASCADE_MACROS_SVH
`define BIQUAD_IIR_CASCADE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQC_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad_iir_cascade: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BQC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad_iir_cascade: assertion failed");

`endif

### hw/rtl/bqc_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade package
// Widths, register map, reset coefficients and shared types of the
// direct-form-I biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

    // Signal and coefficient formats.
    localparam int SIG_W            = 40;
    localparam int SAMPLE_W         = 24;
    localparam int COEF_W           = 32;
    localparam int SIGNAL_FRAC_BITS = 8;

    // Serial multiplier digit size and step count.
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_COUNT = COEF_W / DIGIT_W;
    localparam int CNT_W       = $clog2(DIGIT_COUNT);

    // Five products per section: b0, b1, b2, a1, a2.
    localparam int TAP_COUNT = 5;

    // Section index width; the cascade has at most two sections.
    localparam int SEC_IDX_W = 1;

    // Defaults for the top-level parameters.
    localparam int DEF_SECTION_COUNT   = 2;
    localparam int DEF_COEF_FRAC_BITS  = 30;

    // Configuration port.
    localparam int CFG_W     = 64;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 6;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0_PAIR = 3'd0,
        REG_B1_PAIR = 3'd1,
        REG_B2_PAIR = 3'd2,
        REG_A1_PAIR = 3'd3,
        REG_A2_PAIR = 3'd4
    } reg_idx_t;

    // Reset values: the 30 Hz high-pass set.
    localparam logic [CFG_W-1:0] B0_PAIR_RESET = 64'd4611686019266374619;
    localparam logic [CFG_W-1:0] B1_PAIR_RESET = 64'd9223372039471769674;
    localparam logic [CFG_W-1:0] B2_PAIR_RESET = 64'd4611686019266374619;
    localparam logic [CFG_W-1:0] A1_PAIR_RESET = 64'd9992945945896180454;
    localparam logic [CFG_W-1:0] A2_PAIR_RESET = 64'd3994552274480031637;

    // Saturation bounds of the signal format.
    localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

    // One coefficient per section; index 1 is the high word.
    typedef logic [1:0][COEF_W-1:0] coef_pair_t;

    typedef struct packed {
        coef_pair_t b0;
        coef_pair_t b1;
        coef_pair_t b2;
        coef_pair_t a1;
        coef_pair_t a2;
    } coef_set_t;

    // Control of the serial multipliers.
    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } mac_ctrl_t;

endpackage

### hw/rtl/bqc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Biquad cascade coefficient registers
// APB-style register file holding the five coefficient pair registers.
// ----------------------------------------------------------------------------
module bqc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bqc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bqc_pkg::CFG_W-1:0]     pwdata,
    output logic [bqc_pkg::CFG_W-1:0]     prdata,
    output logic                          pready,
    output bqc_pkg::coef_set_t            coef
);
    import bqc_pkg::*;

    logic [CFG_W-1:0] b0_reg;
    logic [CFG_W-1:0] b1_reg;
    logic [CFG_W-1:0] b2_reg;
    logic [CFG_W-1:0] a1_reg;
    logic [CFG_W-1:0] a2_reg;
    reg_idx_t         reg_idx;
    logic             wr_en;

    // Registers sit on 8-byte boundaries.
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes; addresses beyond the map are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= B0_PAIR_RESET;
            b1_reg <= B1_PAIR_RESET;
            b2_reg <= B2_PAIR_RESET;
            a1_reg <= A1_PAIR_RESET;
            a2_reg <= A2_PAIR_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_B0_PAIR: b0_reg <= pwdata;
                REG_B1_PAIR: b1_reg <= pwdata;
                REG_B2_PAIR: b2_reg <= pwdata;
                REG_A1_PAIR: a1_reg <= pwdata;
                REG_A2_PAIR: a2_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (reg_idx)
            REG_B0_PAIR: prdata = b0_reg;
            REG_B1_PAIR: prdata = b1_reg;
            REG_B2_PAIR: prdata = b2_reg;
            REG_A1_PAIR: prdata = a1_reg;
            REG_A2_PAIR: prdata = a2_reg;
            default:     prdata = '0;
        endcase
    end

    assign coef.b0 = b0_reg;
    assign coef.b1 = b1_reg;
    assign coef.b2 = b2_reg;
    assign coef.a1 = a1_reg;
    assign coef.a2 = a2_reg;

endmodule

### hw/rtl/bqc_serial_mac.sv
// ----------------------------------------------------------------------------
// Biquad cascade digit-serial multiplier
// Serial-parallel multiplier: the signal operand is held in parallel and the
// coefficient shifts in one 4-bit digit per cycle, least significant first.
// The product is rounded to the signal format, ties toward plus infinity.
// ----------------------------------------------------------------------------
module bqc_serial_mac #(
    parameter int FRAC_BITS = bqc_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                   clk,
    input  bqc_pkg::mac_ctrl_t                     ctrl,
    input  logic signed [bqc_pkg::SIG_W-1:0]       operand,
    input  logic [bqc_pkg::COEF_W-1:0]             coef,
    output logic signed [bqc_pkg::SIG_W+bqc_pkg::COEF_W+2-FRAC_BITS-1:0] product
);
    import bqc_pkg::*;

    localparam int ACC_W = SIG_W + 2;
    localparam int T_W   = SIG_W + DIGIT_W + 2;
    localparam int PW    = ACC_W + COEF_W;
    localparam int RW    = PW - FRAC_BITS;

    logic signed [SIG_W-1:0]   opnd_reg;
    logic [COEF_W-1:0]         coef_sr_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [COEF_W-1:0]         low_reg;
    logic signed [DIGIT_W:0]   digit;
    logic signed [T_W-1:0]     term;
    logic signed [T_W-1:0]     sum_next;
    logic [PW-1:0]             p_full;

    // The top digit of the coefficient carries its sign.
    always_comb
    begin
        if (ctrl.last)
            digit = signed'({coef_sr_reg[DIGIT_W-1], coef_sr_reg[DIGIT_W-1:0]});
        else
            digit = signed'({1'b0, coef_sr_reg[DIGIT_W-1:0]});
        term     = T_W'(opnd_reg) * T_W'(digit);
        sum_next = T_W'(acc_reg) + term;
    end

    // Each step adds one partial product and shifts one finished digit out.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            opnd_reg    <= operand;
            coef_sr_reg <= coef;
            acc_reg     <= '0;
        end
        else if (ctrl.step)
        begin
            acc_reg     <= sum_next[T_W-1:DIGIT_W];
            low_reg     <= {sum_next[DIGIT_W-1:0], low_reg[COEF_W-1:DIGIT_W]};
            coef_sr_reg <= coef_sr_reg >> DIGIT_W;
        end
    end

    // Round to nearest: drop the fraction and add its top bit.
    assign p_full  = {acc_reg, low_reg};
    assign product = signed'(p_full[PW-1:FRAC_BITS] + RW'(p_full[FRAC_BITS-1]));

endmodule

### hw/rtl/biquad_iir_cascade.sv
// ----------------------------------------------------------------------------
// Biquad IIR cascade
// Cascade of direct-form-I biquad sections built on five shared digit-serial
// multipliers, one per coefficient of a section.
//
// Usage:
// Samples enter on the sample channel (valid/ready) and results leave on the
// filtered channel (valid/ready) as signed Q32.8 words saturated to 40 bits.
// Coefficients are written over the APB-style port; the user must write them
// only while the block is idle, as the block does not enforce this itself.
// Each section runs one operand load, 8 multiply steps of one 4-bit
// coefficient digit each, one sum and one saturate step. After the last
// section the result passes through the output state, and a new request
// is taken only once the block is back in the idle state.
// Reset loads the 30 Hz high-pass coefficients and clears all history.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted and its result waits until the register is free.
// ----------------------------------------------------------------------------
`include "biquad_iir_cascade_macros.svh"

module biquad_iir_cascade #(
    parameter int SECTION_COUNT  = bqc_pkg::DEF_SECTION_COUNT,
    parameter int COEF_FRAC_BITS = bqc_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bqc_pkg::PADDR_W-1:0]         paddr,
    input  logic [bqc_pkg::CFG_W-1:0]           pwdata,
    output logic [bqc_pkg::CFG_W-1:0]           prdata,
    output logic                                pready,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample,
    output logic                                filtered_valid,
    input  logic                                filtered_ready,
    output logic signed [bqc_pkg::SIG_W-1:0]    filtered
);
    import bqc_pkg::*;

    localparam int PROD_W = SIG_W + COEF_W + 2 - COEF_FRAC_BITS;
    localparam int SUM_W  = PROD_W + 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SUM,
        S_SAT,
        S_OUT
    } state_t;

    state_t                     state_reg;
    logic [SEC_IDX_W-1:0]       sec_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [SIG_W-1:0]    filtered_reg;
    logic                       filtered_valid_reg;
    logic signed [SIG_W-1:0]    sig_reg;
    logic signed [SIG_W-1:0]    x1_reg [SECTION_COUNT];
    logic signed [SIG_W-1:0]    x2_reg [SECTION_COUNT];
    logic signed [SIG_W-1:0]    y1_reg [SECTION_COUNT];
    logic signed [SIG_W-1:0]    y2_reg [SECTION_COUNT];
    logic signed [SUM_W-1:0]    ff_sum_reg;
    logic signed [SUM_W-1:0]    fb_sum_reg;

    coef_set_t                  coef;
    mac_ctrl_t                  mac_ctrl;
    logic signed [SIG_W-1:0]    mac_opnd [TAP_COUNT];
    logic [COEF_W-1:0]          mac_coef [TAP_COUNT];
    logic signed [PROD_W-1:0]   mac_prod [TAP_COUNT];
    logic signed [SIG_W-1:0]    sample_sig;
    logic signed [SUM_W-1:0]    diff;
    logic signed [SIG_W-1:0]    y_sat;
    logic                       last_sec;

    // Coefficient registers.
    bqc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // Operands of the current section.
    always_comb
    begin
        mac_opnd[0] = sig_reg;
        mac_opnd[1] = x1_reg[sec_reg];
        mac_opnd[2] = x2_reg[sec_reg];
        mac_opnd[3] = y1_reg[sec_reg];
        mac_opnd[4] = y2_reg[sec_reg];
        mac_coef[0] = coef.b0[sec_reg];
        mac_coef[1] = coef.b1[sec_reg];
        mac_coef[2] = coef.b2[sec_reg];
        mac_coef[3] = coef.a1[sec_reg];
        mac_coef[4] = coef.a2[sec_reg];
    end

    assign mac_ctrl.load = (state_reg == S_LOAD);
    assign mac_ctrl.step = (state_reg == S_MUL);
    assign mac_ctrl.last = (state_reg == S_MUL) && (cnt_reg == CNT_W'(DIGIT_COUNT - 1));

    // One serial multiplier per coefficient.
    for (genvar t = 0; t < TAP_COUNT; t++)
    begin : g_tap
        bqc_serial_mac #(
            .FRAC_BITS (COEF_FRAC_BITS)
        ) u_mac (
            .clk     (clk),
            .ctrl    (mac_ctrl),
            .operand (mac_opnd[t]),
            .coef    (mac_coef[t]),
            .product (mac_prod[t])
        );
    end

    // Input scaling and output saturation.
    always_comb
    begin
        sample_sig = SIG_W'(sample) <<< SIGNAL_FRAC_BITS;
        diff       = ff_sum_reg - fb_sum_reg;
        if (diff > SUM_W'(SIG_MAX))
            y_sat = SIG_MAX;
        else if (diff < SUM_W'(SIG_MIN))
            y_sat = SIG_MIN;
        else
            y_sat = diff[SIG_W-1:0];
    end

    assign last_sec       = (sec_reg == SEC_IDX_W'(SECTION_COUNT - 1));
    assign sample_ready   = (state_reg == S_IDLE);
    assign filtered_valid = filtered_valid_reg;
    assign filtered       = filtered_reg;

    // Sequencer: one section at a time, then the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            sec_reg            <= '0;
            cnt_reg            <= '0;
            filtered_valid_reg <= 1'b0;
            filtered_reg       <= '0;
        end
        else
        begin
            // Outside the output state, a taken result frees the output register.
            if (filtered_valid_reg && filtered_ready && (state_reg != S_OUT))
                filtered_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                    begin
                        sec_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (mac_ctrl.last)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    if (last_sec)
                        state_reg <= S_OUT;
                    else
                    begin
                        sec_reg   <= sec_reg + 1'b1;
                        state_reg <= S_LOAD;
                    end
                end
                S_OUT:
                begin
                    if (!filtered_valid_reg || filtered_ready)
                    begin
                        filtered_reg       <= sig_reg;
                        filtered_valid_reg <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Section input: the new sample, then each section's output in turn.
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            sig_reg <= sample_sig;
        else if (state_reg == S_SAT)
            sig_reg <= y_sat;
    end

    // Feed-forward and feedback sums of the rounded products.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
        begin
            ff_sum_reg <= SUM_W'(mac_prod[0]) + SUM_W'(mac_prod[1]) + SUM_W'(mac_prod[2]);
            fb_sum_reg <= SUM_W'(mac_prod[3]) + SUM_W'(mac_prod[4]);
        end
    end

    // Delay lines of the current section advance once its output is known.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SECTION_COUNT; s++)
            begin
                x1_reg[s] <= '0;
                x2_reg[s] <= '0;
                y1_reg[s] <= '0;
                y2_reg[s] <= '0;
            end
        end
        else if (state_reg == S_SAT)
        begin
            x2_reg[sec_reg] <= x1_reg[sec_reg];
            x1_reg[sec_reg] <= sig_reg;
            y2_reg[sec_reg] <= y1_reg[sec_reg];
            y1_reg[sec_reg] <= y_sat;
        end
    end

    // An accepted request makes the block busy in the next cycle.
    `BQC_ASSERT_NEXT(a_busy_after_request, sample_valid && sample_ready, !sample_ready)

    // A new result only appears out of the output state.
    `BQC_ASSERT_IMPLIES(a_result_from_out, $rose(filtered_valid), $past(state_reg) == S_OUT)

    // Every sum step follows exactly one full pass over the coefficient digits.
    `BQC_ASSERT_IMPLIES(a_full_digit_pass, state_reg == S_SUM,
        $past(state_reg, DIGIT_COUNT + 1) == S_LOAD)

    // The section index never passes the last section.
    `BQC_ASSERT_IMPLIES(a_section_range, state_reg != S_IDLE,
        sec_reg <= SEC_IDX_W'(SECTION_COUNT - 1))

endmodule

### test/biquad_iir_cascade_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR cascade testbench
// Sends samples into the two-section biquad cascade under random flow
// control, writes several coefficient sets over the APB port and compares
// every filtered output with a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
module biquad_iir_cascade_tb;
    import bqc_pkg::*;

    localparam int SECTIONS      = DEF_SECTION_COUNT;
    localparam int COEF_FRAC     = DEF_COEF_FRAC_BITS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PERCENT  = 17;
    localparam int MAX_REPORTS   = 10;
    localparam int STABLE_PHASES = 5;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [79:0] ACC_MAX = 80'sh7F_FFFF_FFFF;
    localparam logic signed [79:0] ACC_MIN = -80'sh80_0000_0000;

    // Scoreboard: predicts the cascade output and holds the outputs still due.
    class biquad_scoreboard;
        logic [CFG_W-1:0]        coef_reg [TAP_COUNT];
        logic signed [SIG_W-1:0] x_hist [SECTIONS][2];
        logic signed [SIG_W-1:0] y_hist [SECTIONS][2];
        logic signed [SIG_W-1:0] expected_filtered [$];
        int                      mismatches;

        function new();
            coef_reg[REG_B0_PAIR] = B0_PAIR_RESET;
            coef_reg[REG_B1_PAIR] = B1_PAIR_RESET;
            coef_reg[REG_B2_PAIR] = B2_PAIR_RESET;
            coef_reg[REG_A1_PAIR] = A1_PAIR_RESET;
            coef_reg[REG_A2_PAIR] = A2_PAIR_RESET;
            for (int k = 0; k < SECTIONS; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    x_hist[k][j] = '0;
                    y_hist[k][j] = '0;
                end
            end
            mismatches = 0;
        endfunction

        function void write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
            coef_reg[idx] = value;
        endfunction

        function void note_mismatch(string what, logic [CFG_W-1:0] want,
                                    logic [CFG_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        endfunction

        function logic signed [COEF_W-1:0] coef_word(reg_idx_t idx, int sec);
            return coef_reg[idx][COEF_W*sec +: COEF_W];
        endfunction

        // Exact product, rounded to the signal format with ties toward plus infinity.
        function logic signed [79:0] round_product(logic signed [SIG_W-1:0] sig,
                                                   logic signed [COEF_W-1:0] coef);
            logic signed [79:0] prod;
            prod = signed'({{(80-SIG_W){sig[SIG_W-1]}}, sig})
                 * signed'({{(80-COEF_W){coef[COEF_W-1]}}, coef});
            prod = prod + (80'sd1 <<< (COEF_FRAC - 1));
            return prod >>> COEF_FRAC;
        endfunction

        // Run one sample through every section and queue the cascade output.
        function void accept_sample(logic signed [SAMPLE_W-1:0] value);
            logic signed [79:0]      acc;
            logic signed [SIG_W-1:0] sig;
            logic signed [SIG_W-1:0] y;
            sig = {{(SIG_W-SAMPLE_W){value[SAMPLE_W-1]}}, value};
            sig = sig <<< SIGNAL_FRAC_BITS;
            for (int k = 0; k < SECTIONS; k++)
            begin
                acc = round_product(sig, coef_word(REG_B0_PAIR, k))
                    + round_product(x_hist[k][0], coef_word(REG_B1_PAIR, k))
                    + round_product(x_hist[k][1], coef_word(REG_B2_PAIR, k))
                    - round_product(y_hist[k][0], coef_word(REG_A1_PAIR, k))
                    - round_product(y_hist[k][1], coef_word(REG_A2_PAIR, k));
                if (acc > ACC_MAX)
                    y = SIG_MAX;
                else if (acc < ACC_MIN)
                    y = SIG_MIN;
                else
                    y = acc[SIG_W-1:0];
                x_hist[k][1] = x_hist[k][0];
                x_hist[k][0] = sig;
                y_hist[k][1] = y_hist[k][0];
                y_hist[k][0] = y;
                sig = y;
            end
            expected_filtered.push_back(sig);
        endfunction

        function void check_filtered(logic signed [SIG_W-1:0] actual);
            logic signed [SIG_W-1:0] want;
            if (expected_filtered.size() == 0)
            begin
                note_mismatch("filtered output with no sample pending", '0,
                              {{(CFG_W-SIG_W){1'b0}}, actual});
                return;
            end
            want = expected_filtered.pop_front();
            if (actual !== want)
                note_mismatch("filtered", {{(CFG_W-SIG_W){1'b0}}, want},
                              {{(CFG_W-SIG_W){1'b0}}, actual});
        endfunction

        function void check_register(reg_idx_t idx, logic [CFG_W-1:0] got);
            if (got !== coef_reg[idx])
                note_mismatch("register read-back", coef_reg[idx], got);
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [CFG_W-1:0]            pwdata;
    logic [CFG_W-1:0]            prdata;
    logic                        pready;
    logic                        sample_valid;
    logic                        sample_ready;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        filtered_valid;
    logic                        filtered_ready;
    logic signed [SIG_W-1:0]     filtered;

    biquad_scoreboard model = new();
    bit                          idle_enabled = 1'b1;
    bit                          hold_request = 1'b0;
    int                          hold_left    = 0;
    int                          cycle_count  = 0;

    biquad_iir_cascade i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample         (sample),
        .filtered_valid (filtered_valid),
        .filtered_ready (filtered_ready),
        .filtered       (filtered)
    );

    // Clock with an 8 ns period.
    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // Run limit; a hang ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial
    begin
        filtered_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                filtered_ready = 1'b0;
            end
            else
                filtered_ready = !idle_enabled || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clk);
            if (filtered_valid && filtered_ready)
                model.check_filtered(filtered);
        end
    end

    // Write one register, then read it back in the following transfer.
    task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model.write_register(idx, value);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        model.check_register(idx, got);
    endtask

    task automatic write_coefs(input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] b1,
                               input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] a1,
                               input logic [CFG_W-1:0] a2);
        write_register(REG_B0_PAIR, b0);
        write_register(REG_B1_PAIR, b1);
        write_register(REG_B2_PAIR, b2);
        write_register(REG_A1_PAIR, a1);
        write_register(REG_A2_PAIR, a2);
    endtask

    // Offer one sample request and hold it until it is taken.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        while (idle_enabled && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample       = value;
        do
            @(posedge clk);
        while (!sample_ready);
        model.accept_sample(value);
        @(negedge clk);
    endtask

    // Stop offering and wait until every pending output has arrived.
    task automatic wait_drained();
        sample_valid = 1'b0;
        while (model.expected_filtered.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic [31:0] rnd;
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3:
            begin
                rnd = 32'($urandom_range(512)) - 32'd256;
                return rnd[SAMPLE_W-1:0];
            end
            default:
            begin
                rnd = $urandom;
                return rnd[SAMPLE_W-1:0];
            end
        endcase
    endfunction

    // Pair of coefficients drawn from [-span, span] for both sections.
    function automatic logic [CFG_W-1:0] coef_pair(input int unsigned span);
        logic [COEF_W-1:0] lo;
        logic [COEF_W-1:0] hi;
        lo = $urandom_range(2 * span) - span;
        hi = $urandom_range(2 * span) - span;
        return {hi, lo};
    endfunction

    task automatic run_samples(input int count, input bit mid_pause);
        for (int n = 0; n < count; n++)
        begin
            if (mid_pause && n == count / 2)
                wait_drained();
            send_sample(random_sample());
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sample_valid = 1'b0;
        sample       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset high-pass set with the sample extremes and small steps.
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        wait_drained();

        // Section 0 scales its input by 2^-9, so odd samples hit rounding ties;
        // section 1 passes its input through.
        write_coefs({32'h4000_0000, 32'h0020_0000}, '0, '0, '0, '0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sd3);
        send_sample(-24'sd3);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_drained();

        // Extreme coefficients drive the accumulator into saturation.
        write_coefs(64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
                    64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        wait_drained();

        // All-zero coefficients.
        write_coefs('0, '0, '0, '0, '0);
        run_samples(40, 1'b0);
        wait_drained();

        // Fully random coefficient words.
        write_coefs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_samples(150, 1'b0);
        wait_drained();

        // Stable random filters: one phase without idling, one with a long
        // output hold-off, one with a pause until all outputs are back.
        for (int p = 0; p < STABLE_PHASES; p++)
        begin
            write_coefs(coef_pair(32'h4000_0000), coef_pair(32'h4000_0000),
                        coef_pair(32'h4000_0000), coef_pair(32'h2000_0000),
                        coef_pair(32'h1000_0000));
            idle_enabled = (p != 1);
            if (p == 2)
                hold_request = 1'b1;
            run_samples(300, p == 3);
            wait_drained();
        end

        // Back to the reset high-pass set.
        idle_enabled = 1'b1;
        write_coefs(B0_PAIR_RESET, B1_PAIR_RESET, B2_PAIR_RESET,
                    A1_PAIR_RESET, A2_PAIR_RESET);
        run_samples(200, 1'b0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (model.mismatches == 0 && model.expected_filtered.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
